// ===== rtl/dssm_pkg.sv =====
// dssm_pkg: shared types, codes and segment map tables for the seven-segment mapper
// depends on nothing; used by all rtl files
package dssm_pkg;

  typedef enum logic [2:0] {
    ACT_NUMBER = 3'd0,
    ACT_FIX41  = 3'd1,
    ACT_FIX31  = 3'd2,
    ACT_GLYPH  = 3'd3,
    ACT_SYMBOL = 3'd4,
    ACT_RAW    = 3'd5
  } action_t;

  localparam logic [3:0] CODE_BLANK = 4'd10;
  localparam logic [3:0] CODE_MINUS = 4'd11;
  localparam logic [2:0] SEG_LETTER_NONE = 3'd7;
  localparam int ROM_DIGITS  = 15;
  localparam int ROM_SYMBOLS = 37;

  typedef struct packed {
    logic       start;
    logic [3:0] ndig;
    logic [31:0] value;
  } conv_req_t;

  function automatic logic [6:0] font(input logic [3:0] code);
    logic [6:0] p;
    case (code)
      4'd0: p = 7'h3F;
      4'd1: p = 7'h06;
      4'd2: p = 7'h5B;
      4'd3: p = 7'h4F;
      4'd4: p = 7'h66;
      4'd5: p = 7'h6D;
      4'd6: p = 7'h7D;
      4'd7: p = 7'h07;
      4'd8: p = 7'h7F;
      4'd9: p = 7'h6F;
      CODE_MINUS: p = 7'h40;
      default: p = 7'h00;
    endcase
    return p;
  endfunction

  function automatic logic [31:0] pow10(input logic [3:0] k);
    logic [31:0] p;
    case (k)
      4'd0: p = 32'd1;
      4'd1: p = 32'd10;
      4'd2: p = 32'd100;
      4'd3: p = 32'd1000;
      4'd4: p = 32'd10000;
      4'd5: p = 32'd100000;
      4'd6: p = 32'd1000000;
      4'd7: p = 32'd10000000;
      4'd8: p = 32'd100000000;
      default: p = 32'd1000000000;
    endcase
    return p;
  endfunction

  function automatic logic [8:0] digit_rom(input logic [3:0] pos, input logic [2:0] seg);
    logic [8:0] t [0:104];
    logic [6:0] a;
    t = '{9'd186, 9'd192, 9'd195, 9'd174, 9'd177, 9'd184, 9'd183,
          9'd210, 9'd214, 9'd217, 9'd197, 9'd201, 9'd207, 9'd204,
          9'd234, 9'd238, 9'd239, 9'd221, 9'd224, 9'd230, 9'd227,
          9'd258, 9'd262, 9'd263, 9'd243, 9'd246, 9'd252, 9'd249,
          9'd280, 9'd284, 9'd287, 9'd268, 9'd271, 9'd275, 9'd274,
          9'd94, 9'd95, 9'd96, 9'd90, 9'd91, 9'd93, 9'd92,
          9'd101, 9'd102, 9'd103, 9'd97, 9'd98, 9'd100, 9'd99,
          9'd108, 9'd109, 9'd110, 9'd104, 9'd105, 9'd107, 9'd106,
          9'd115, 9'd116, 9'd117, 9'd111, 9'd112, 9'd114, 9'd113,
          9'd78, 9'd79, 9'd81, 9'd82, 9'd83, 9'd77, 9'd80,
          9'd67, 9'd68, 9'd69, 9'd63, 9'd64, 9'd66, 9'd65,
          9'd74, 9'd75, 9'd76, 9'd70, 9'd71, 9'd73, 9'd72,
          9'd59, 9'd53, 9'd54, 9'd55, 9'd56, 9'd58, 9'd57,
          9'd52, 9'd46, 9'd47, 9'd48, 9'd49, 9'd51, 9'd50,
          9'd38, 9'd39, 9'd41, 9'd42, 9'd43, 9'd45, 9'd40};
    a = 7'(pos) * 7'd7 + 7'(seg);
    return (a < 7'd105) ? t[a] : 9'd0;
  endfunction

  function automatic logic [8:0] symbol_rom(input logic [5:0] idx);
    logic [8:0] t [0:36];
    t = '{9'd294, 9'd295, 9'd296, 9'd297, 9'd84, 9'd150, 9'd305, 9'd266, 9'd331, 9'd330,
          9'd324, 9'd312, 9'd126, 9'd129, 9'd118, 9'd150, 9'd151, 9'd136, 9'd154, 9'd335,
          9'd344, 9'd348, 9'd347, 9'd85, 9'd84, 9'd342, 9'd322, 9'd0, 9'd60, 9'd44,
          9'd309, 9'd343, 9'd320, 9'd306, 9'd29, 9'd24, 9'd20};
    return (idx < 6'd37) ? t[idx] : 9'd0;
  endfunction

endpackage

// ===== rtl/dssm_conv.sv =====
// dssm_conv: iterative decimal digit extractor, one subtract-compare per cycle
// depends on dssm_pkg
module dssm_conv (
  input  logic                clk,
  input  logic                rst_n,
  input  dssm_pkg::conv_req_t req,
  output logic                done,
  output logic                ovf,
  output logic [9:0][3:0]     digits
);
  import dssm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} st_t;
  st_t st_r;
  logic [31:0]     rem_r;
  logic [3:0]      k_r;
  logic [3:0]      dig_r;
  logic [3:0]      nd_r;
  logic [9:0][3:0] d_r;
  logic            ovf_r;
  logic [31:0]     pw_cur;

  assign pw_cur = pow10(k_r);

  // digit k found by repeated subtraction of 10^k, top digit first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      ovf_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: if (req.start) begin
          rem_r <= req.value;
          nd_r  <= req.ndig;
          k_r   <= 4'd9;
          dig_r <= 4'd0;
          ovf_r <= 1'b0;
          st_r  <= S_RUN;
        end
        S_RUN: begin
          if (rem_r >= pw_cur && !(k_r == 4'd9 && dig_r == 4'd4)) begin
            rem_r <= rem_r - pw_cur;
            dig_r <= dig_r + 4'd1;
          end else begin
            d_r[k_r] <= dig_r;
            if (dig_r != 4'd0 && k_r >= nd_r) ovf_r <= 1'b1;
            dig_r <= 4'd0;
            if (k_r == 4'd0) st_r <= S_DONE;
            else k_r <= k_r - 4'd1;
          end
        end
        S_DONE: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign done   = (st_r == S_DONE);
  assign ovf    = ovf_r;
  assign digits = d_r;
endmodule

// ===== rtl/decimal_seven_segment_mapper_core.sv =====
// decimal_seven_segment_mapper_core: command sequencer and segment write emitter
// depends on dssm_pkg and dssm_conv
// A command is taken when the block is idle (in_stall low). Number and valid fixed-point
// commands first run the value through a repeated subtraction unit, one step per cycle,
// that finds each decimal digit by subtracting its power of ten, top digit first. Writes
// then leave at most one per cycle while out_stall is low, seven per glyph; a glyph at
// a position out of range is skipped with no writes and a flush state closes the command.
// Each write waits one stage so the final one can carry out_last; in_stall falls once
// that write is handed to the output register, before it has been taken.
module decimal_seven_segment_mapper_core #(
  parameter int DIGIT_COUNT      = 15,
  parameter int SYMBOL_COUNT     = 37,
  parameter int MAX_FIELD_DIGITS = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_action,
  input  logic [4:0]        in_start_pos,
  input  logic [3:0]        in_count,
  input  logic [31:0]       in_number_value,
  input  logic              in_zero_pad,
  input  logic              in_fixed_valid,
  input  logic [5:0]        in_symbol_number,
  input  logic signed [7:0] in_glyph_value,
  input  logic [2:0]        in_segment_letter,
  input  logic              in_seg_on,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [8:0]        out_segment_index,
  output logic              out_segment_state,
  output logic              out_last
);
  import dssm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CONV, S_WAIT, S_INT, S_DOT, S_FRAC, S_SYM, S_RAW, S_FLUSH
  } st_t;

  st_t         st_r, st_nxt;
  logic [2:0]  act_r, act_nxt;
  logic [4:0]  first_r, first_nxt;
  logic [3:0]  n_r, n_nxt;
  logic [31:0] val_r, val_nxt;
  logic        lz_r, lz_nxt;
  logic        fv_r, fv_nxt;
  logic        on_r, on_nxt;
  logic [5:0]  sym_r, sym_nxt;
  logic [3:0]  code_r, code_nxt;
  logic [2:0]  let_r, let_nxt;
  logic [3:0]  g_r, g_nxt;
  logic [2:0]  s_r, s_nxt;
  logic        hold_v_r, hold_v_nxt;
  logic [8:0]  hold_idx_r, hold_idx_nxt;
  logic        hold_st_r, hold_st_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [8:0]  out_idx_r, out_idx_nxt;
  logic        out_st_r, out_st_nxt;
  logic        out_last_r, out_last_nxt;

  conv_req_t       req;
  logic            cdone, covf;
  logic [9:0][3:0] cdig;

  logic [3:0]  cnt_c;
  logic        fixed_c, asc_c, nz;
  logic [3:0]  dj;
  logic [3:0]  code_c;
  logic [6:0]  pat;
  logic [5:0]  first_w, n_w, g_w, pos_c;
  logic        pos_ok, sym_ok;
  logic [8:0]  seg_idx_c, sym_idx_c;
  logic        out_free, gen_ok;
  logic        wr_req, wr_st;
  logic [8:0]  wr_idx;

  assign cnt_c = (in_count > 4'(MAX_FIELD_DIGITS)) ? 4'(MAX_FIELD_DIGITS) : in_count;

  assign fixed_c = (act_r == ACT_FIX41) || (act_r == ACT_FIX31);
  // overflow eights, dashes and single glyphs go left to right, digits right to left
  assign asc_c   = (act_r == ACT_NUMBER && covf) || (fixed_c && !fv_r) ||
                   (act_r == ACT_GLYPH);

  // glyph code for the current position
  always_comb begin
    dj = g_r + (fixed_c ? 4'd1 : 4'd0);
    nz = 1'b0;
    for (int k = 0; k < 10; k++) begin
      if (4'(k) >= dj && 4'(k) <= n_r && cdig[k] != 4'd0) nz = 1'b1;
    end
    if (st_r == S_FRAC) code_c = fv_r ? cdig[0] : CODE_BLANK;
    else if (act_r == ACT_GLYPH) code_c = code_r;
    else if (fixed_c && !fv_r) code_c = CODE_MINUS;
    else if (act_r == ACT_NUMBER && covf) code_c = 4'd8;
    else if (g_r == 4'd0 || nz) code_c = cdig[dj];
    else if (lz_r && act_r == ACT_NUMBER) code_c = 4'd0;
    else code_c = CODE_BLANK;
  end

  assign first_w   = {1'b0, first_r};
  assign n_w       = {2'b00, n_r};
  assign g_w       = {2'b00, g_r};
  assign pos_c     = (st_r == S_FRAC) ? first_w + n_w :
                     (st_r == S_RAW)  ? first_w :
                     asc_c ? first_w + g_w : first_w + n_w - 6'd1 - g_w;
  assign pos_ok    = pos_c >= 6'd1 && pos_c <= 6'(DIGIT_COUNT) && pos_c <= 6'(ROM_DIGITS);
  assign sym_ok    = sym_r >= 6'd1 && sym_r <= 6'(SYMBOL_COUNT) && sym_r <= 6'(ROM_SYMBOLS);
  assign pat       = font(code_c);
  assign seg_idx_c = digit_rom(4'(pos_c - 6'd1), (st_r == S_RAW) ? let_r : s_r);
  assign sym_idx_c = symbol_rom(sym_r - 6'd1);

  assign req.start = (st_r == S_CONV);
  assign req.ndig  = n_r;
  assign req.value = val_r;

  dssm_conv u_conv (.clk(clk), .rst_n(rst_n), .req(req), .done(cdone), .ovf(covf),
                    .digits(cdig));

  assign out_free = !out_valid_r || !out_stall;
  assign gen_ok   = !hold_v_r || out_free;
  assign in_stall = (st_r != S_IDLE);

  always_comb begin
    st_nxt        = st_r;
    act_nxt       = act_r;
    first_nxt     = first_r;
    n_nxt         = n_r;
    val_nxt       = val_r;
    lz_nxt        = lz_r;
    fv_nxt        = fv_r;
    on_nxt        = on_r;
    sym_nxt       = sym_r;
    code_nxt      = code_r;
    let_nxt       = let_r;
    g_nxt         = g_r;
    s_nxt         = s_r;
    hold_v_nxt    = hold_v_r;
    hold_idx_nxt  = hold_idx_r;
    hold_st_nxt   = hold_st_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;
    wr_req        = 1'b0;
    wr_idx        = seg_idx_c;
    wr_st         = pat[s_r];
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: if (in_valid) begin
        act_nxt   = in_action;
        first_nxt = in_start_pos;
        lz_nxt    = in_zero_pad;
        fv_nxt    = in_fixed_valid;
        sym_nxt   = in_symbol_number;
        let_nxt   = in_segment_letter;
        on_nxt    = in_seg_on;
        val_nxt   = in_number_value;
        g_nxt     = 4'd0;
        s_nxt     = 3'd0;
        code_nxt  = (in_glyph_value >= 8'sd0 && in_glyph_value <= 8'sd9) ?
                    in_glyph_value[3:0] :
                    (in_glyph_value == -8'sd2) ? CODE_MINUS : CODE_BLANK;
        unique case (in_action) inside
          ACT_NUMBER: begin
            n_nxt  = cnt_c;
            st_nxt = (cnt_c == 4'd0) ? S_IDLE : S_CONV;
          end
          ACT_FIX41, ACT_FIX31: begin
            n_nxt  = (in_action == ACT_FIX41) ? 4'd4 : 4'd3;
            st_nxt = in_fixed_valid ? S_CONV : S_INT;
          end
          ACT_GLYPH: begin
            n_nxt  = 4'd1;
            st_nxt = S_INT;
          end
          ACT_SYMBOL: st_nxt = S_SYM;
          ACT_RAW:    st_nxt = S_RAW;
          default:    st_nxt = S_IDLE;
        endcase
      end
      S_CONV: st_nxt = S_WAIT;
      S_WAIT: if (cdone) st_nxt = S_INT;
      S_INT: begin
        if (!pos_ok || (gen_ok && s_r == 3'd6)) begin
          if (pos_ok) wr_req = 1'b1;
          s_nxt = 3'd0;
          if (g_r == n_r - 4'd1) st_nxt = fixed_c ? S_DOT : S_FLUSH;
          else g_nxt = g_r + 4'd1;
        end else if (gen_ok) begin
          wr_req = 1'b1;
          s_nxt  = s_r + 3'd1;
        end
      end
      S_DOT: begin
        if (!sym_ok) begin
          st_nxt = S_FRAC;
        end else if (gen_ok) begin
          wr_req = 1'b1;
          wr_idx = sym_idx_c;
          wr_st  = fv_r;
          st_nxt = S_FRAC;
        end
      end
      S_FRAC: begin
        if (!pos_ok) begin
          st_nxt = S_FLUSH;
        end else if (gen_ok) begin
          wr_req = 1'b1;
          if (s_r == 3'd6) st_nxt = S_FLUSH;
          else s_nxt = s_r + 3'd1;
        end
      end
      S_SYM: begin
        if (!sym_ok) begin
          st_nxt = S_FLUSH;
        end else if (gen_ok) begin
          wr_req = 1'b1;
          wr_idx = sym_idx_c;
          wr_st  = on_r;
          st_nxt = S_FLUSH;
        end
      end
      S_RAW: begin
        if (!pos_ok || let_r == SEG_LETTER_NONE) begin
          st_nxt = S_FLUSH;
        end else if (gen_ok) begin
          wr_req = 1'b1;
          wr_st  = on_r;
          st_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!hold_v_r) begin
          st_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = hold_idx_r;
          out_st_nxt    = hold_st_r;
          out_last_nxt  = 1'b1;
          hold_v_nxt    = 1'b0;
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    // the held write moves out once the next one of the same item exists
    if (wr_req) begin
      if (hold_v_r) begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = hold_idx_r;
        out_st_nxt    = hold_st_r;
        out_last_nxt  = 1'b0;
      end
      hold_v_nxt   = 1'b1;
      hold_idx_nxt = wr_idx;
      hold_st_nxt  = wr_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      act_r       <= 3'd0;
      first_r     <= 5'd0;
      n_r         <= 4'd0;
      val_r       <= 32'd0;
      lz_r        <= 1'b0;
      fv_r        <= 1'b0;
      on_r        <= 1'b0;
      sym_r       <= 6'd0;
      code_r      <= 4'd0;
      let_r       <= 3'd0;
      g_r         <= 4'd0;
      s_r         <= 3'd0;
      hold_v_r    <= 1'b0;
      hold_idx_r  <= 9'd0;
      hold_st_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_idx_r   <= 9'd0;
      out_st_r    <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      act_r       <= act_nxt;
      first_r     <= first_nxt;
      n_r         <= n_nxt;
      val_r       <= val_nxt;
      lz_r        <= lz_nxt;
      fv_r        <= fv_nxt;
      on_r        <= on_nxt;
      sym_r       <= sym_nxt;
      code_r      <= code_nxt;
      let_r       <= let_nxt;
      g_r         <= g_nxt;
      s_r         <= s_nxt;
      hold_v_r    <= hold_v_nxt;
      hold_idx_r  <= hold_idx_nxt;
      hold_st_r   <= hold_st_nxt;
      out_valid_r <= out_valid_nxt;
      out_idx_r   <= out_idx_nxt;
      out_st_r    <= out_st_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_segment_index = out_idx_r;
  assign out_segment_state = out_st_r;
  assign out_last          = out_last_r;
endmodule
